FILE: design/asa_pkg.sv
// Shared types and constants for the aligned stack allocator.
// Used by asa_rec_mem, asa_ctrl, aligned_stack_allocator, alloc_checker and testbench; no dependencies.
`default_nettype none

package asa_pkg;

  // Field widths of the request and result transactions
  localparam int unsigned OFS_W     = 21;  // byte offsets and byte totals
  localparam int unsigned SIZE_W    = 20;
  localparam int unsigned ALIGN_W   = 4;
  localparam int unsigned CNT_OUT_W = 7;

  // Arithmetic widths
  localparam int unsigned PAD_W = 15;  // padding is below the largest alignment, 2^15
  localparam int unsigned SUM_W = 22;  // top plus a 21-bit operand
  localparam int unsigned END_W = 23;  // padded new top, compared against the arena end

  // Allocator geometry
  localparam int unsigned OFFSET_BITS   = 20;
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned MAX_DEPTH_DEF = 64;

  localparam logic [END_W-1:0] ARENA_CAP   = END_W'(64'd1 << OFFSET_BITS);
  localparam logic [OFS_W-1:0] ARENA_RESET = OFS_W'(1048576);

  // Request kinds carried on the request tuser
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_ORDER   = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_PAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               req_type;   // 0 allocate, 1 free
    logic [SIZE_W-1:0]  size_bytes;
    logic [ALIGN_W-1:0] align_log2;
    logic [SIZE_W-1:0]  align_bias;
    logic [OFS_W-1:0]   user_offset;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [OFS_W-1:0]     block_offset;
    logic [OFS_W-1:0]     top_offset;
    logic [CNT_OUT_W-1:0] block_count;
    logic [OFS_W-1:0]     used_bytes;
    logic [OFS_W-1:0]     waste_bytes;
    logic [CNT_OUT_W-1:0] count_peak;
    logic [OFS_W-1:0]     used_peak;
    logic [OFS_W-1:0]     waste_peak;
  } res_t;

  // One block record: top before the allocation and the user offset handed out
  typedef struct packed {
    logic [OFS_W-1:0] saved_top;
    logic [OFS_W-1:0] user;
  } rec_t;

endpackage

`default_nettype wire

FILE: design/asa_rec_mem.sv
// Block record stack: one write port, one read port, registered read data.
// Depends on asa_pkg for the record type.
`default_nettype none

module asa_rec_mem #(
  parameter int unsigned MAX_DEPTH = asa_pkg::MAX_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rd_en,
  input  wire [$clog2(MAX_DEPTH)-1:0] rd_addr,
  output asa_pkg::rec_t               rd_data,
  input  wire                         wr_en,
  input  wire [$clog2(MAX_DEPTH)-1:0] wr_addr,
  input  asa_pkg::rec_t               wr_data
);
  import asa_pkg::*;

  rec_t mem [MAX_DEPTH];

  // Write one record
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one record; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/asa_ctrl.sv
// Allocator sequencer: request register, alignment arithmetic, running
// statistics and the result register. Depends on asa_pkg; drives asa_rec_mem.
`default_nettype none

module asa_ctrl #(
  parameter int unsigned MAX_DEPTH = asa_pkg::MAX_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [asa_pkg::OFS_W-1:0]      arena_bytes,
  input  wire                           s_valid,
  output logic                          s_ready,
  input  asa_pkg::req_t                 s_req,
  output logic                          m_valid,
  input  wire                           m_ready,
  output asa_pkg::res_t                 m_res,
  output logic                          mem_rd_en,
  output logic [$clog2(MAX_DEPTH)-1:0]  mem_rd_addr,
  input  asa_pkg::rec_t                 mem_rd_data,
  output logic                          mem_wr_en,
  output logic [$clog2(MAX_DEPTH)-1:0]  mem_wr_addr,
  output asa_pkg::rec_t                 mem_wr_data
);
  import asa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);

  state_t state, state_next;

  // Request and intermediate results
  req_t             req_q;
  logic [PAD_W-1:0] sum_q;
  logic [SUM_W-1:0] base_q;
  logic [PAD_W-1:0] pad_q;
  logic             match_q;

  // Allocator state and statistics
  logic [OFS_W-1:0] top;
  logic [OFS_W-1:0] waste;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_max;
  logic [OFS_W-1:0] used_max;
  logic [OFS_W-1:0] waste_max;

  logic out_valid;
  res_t out_q;

  // Commit datapath
  logic             load;
  logic [END_W-1:0] arena_end;
  logic [END_W-1:0] new_top;
  logic [PAD_W-1:0] pad_mask;
  logic [OFS_W-1:0] user_new;
  logic [OFS_W-1:0] waste_inc;
  logic             full, empty, no_space, alloc_ok, free_ok;
  status_t          status;
  logic [OFS_W-1:0] top_next;
  logic [OFS_W-1:0] waste_next;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    count_max_next;
  logic [OFS_W-1:0] used_max_next;
  logic [OFS_W-1:0] waste_max_next;

  // Work out the outcome of the held request
  always_comb begin
    arena_end = (END_W'(arena_bytes) > ARENA_CAP) ? ARENA_CAP : END_W'(arena_bytes);
    pad_mask  = ~({PAD_W{1'b1}} << req_q.align_log2);
    full      = count >= CW'(MAX_DEPTH);
    empty     = count == '0;
    new_top   = END_W'(base_q) + END_W'(pad_q);
    no_space  = new_top > arena_end;
    user_new  = top + OFS_W'(HEADER_BYTES) + OFS_W'(pad_q);
    waste_inc = waste + OFS_W'(pad_q);
    alloc_ok  = !req_q.req_type && !full && !no_space;
    free_ok   = req_q.req_type && !empty && match_q;

    if (req_q.req_type) begin
      status = empty ? ST_EMPTY : (!match_q ? ST_ORDER : ST_OK);
    end else begin
      status = full ? ST_FULL : (no_space ? ST_NOSPACE : ST_OK);
    end

    top_next       = top;
    waste_next     = waste;
    count_next     = count;
    count_max_next = count_max;
    used_max_next  = used_max;
    waste_max_next = waste_max;
    if (alloc_ok) begin
      top_next       = new_top[OFS_W-1:0];
      waste_next     = waste_inc;
      count_next     = count + CW'(1);
      count_max_next = (count_next > count_max) ? count_next : count_max;
      used_max_next  = (top_next > used_max) ? top_next : used_max;
      waste_max_next = (waste_inc > waste_max) ? waste_inc : waste_max;
    end else if (free_ok) begin
      top_next   = mem_rd_data.saved_top;
      waste_next = waste - OFS_W'(pad_q);
      count_next = count - CW'(1);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and memory access
  always_comb begin
    state_next  = state;
    s_ready     = 1'b0;
    load        = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(count - CW'(1));
    mem_wr_en   = 1'b0;
    mem_wr_addr = count[AW-1:0];
    mem_wr_data = '{saved_top: top, user: user_new};
    case (state)
      S_IDLE: begin
        s_ready   = 1'b1;
        mem_rd_en = s_valid && s_req.req_type && !empty;
        if (s_valid) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_PAD;
      end
      S_PAD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        load      = !out_valid || m_ready;
        mem_wr_en = load && alloc_ok;
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture the request and step the alignment arithmetic
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      req_q <= s_req;
    end
    if (state == S_SUM) begin
      sum_q   <= PAD_W'(SUM_W'(top) + SUM_W'(req_q.align_bias) + SUM_W'(HEADER_BYTES));
      base_q  <= SUM_W'(top) + SUM_W'(HEADER_BYTES) + SUM_W'(req_q.size_bytes);
      match_q <= req_q.user_offset == mem_rd_data.user;
      if (req_q.req_type) begin
        pad_q <= PAD_W'(mem_rd_data.user - mem_rd_data.saved_top - OFS_W'(HEADER_BYTES));
      end
    end
    if (state == S_PAD && !req_q.req_type) begin
      pad_q <= (~sum_q + PAD_W'(1)) & pad_mask;
    end
  end

  // Commit state and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= '0;
      waste     <= '0;
      count     <= '0;
      count_max <= '0;
      used_max  <= '0;
      waste_max <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        top       <= top_next;
        waste     <= waste_next;
        count     <= count_next;
        count_max <= count_max_next;
        used_max  <= used_max_next;
        waste_max <= waste_max_next;
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_q.status       <= status;
      out_q.block_offset <= alloc_ok ? user_new : '0;
      out_q.top_offset   <= top_next;
      out_q.block_count  <= CNT_OUT_W'(count_next);
      out_q.used_bytes   <= top_next;
      out_q.waste_bytes  <= waste_next;
      out_q.count_peak   <= CNT_OUT_W'(count_max_next);
      out_q.used_peak    <= used_max_next;
      out_q.waste_peak   <= waste_max_next;
    end
  end

  assign m_valid = out_valid;
  assign m_res   = out_q;

  a_waste_le_used: assert property (@(posedge clk) disable iff (rst)
    waste <= top) else $error("alignment waste exceeds bytes in use");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_DEPTH)) else $error("live block count beyond record depth");

  a_peaks: assert property (@(posedge clk) disable iff (rst)
    count_max >= count && used_max >= top && waste_max >= waste)
    else $error("peak statistic below current value");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> count < CW'(MAX_DEPTH)) else $error("record push on full stack");

  a_pop_live: assert property (@(posedge clk) disable iff (rst)
    mem_rd_en |-> count != '0) else $error("record read with no live blocks");

endmodule

`default_nettype wire

FILE: design/aligned_stack_allocator.sv
// Aligned LIFO bump allocator: arena size register, stream packing and the
// record memory. Depends on asa_pkg, asa_rec_mem and asa_ctrl.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser is the request kind (0 allocate,
//   1 free), s_tdata carries size, alignment and the offset to free. Every
//   request yields exactly one result on the m_ channel: m_tuser is the status,
//   m_tdata the new block offset, the top and the running statistics.
//   cfg_wen/cfg_wdata set the arena size; write it only while no request is
//   in flight.
//   Sequencing: one request at a time. Each request takes the sequencer
//   through capture (and record read on a free), sum, pad and commit; the
//   registered record memory read and the alignment add chain set these steps.
//   The next request is taken the cycle after commit, while the result may
//   still wait in the output register.
//   Receiver stall: a request that reaches commit waits there until the
//   output register is free; no result is dropped.
//   Reset: top, counts and peaks clear, arena size returns to 1 MiB; the
//   record memory is not cleared and needs no clearing pass.
`default_nettype none

module aligned_stack_allocator #(
  parameter int unsigned MAX_DEPTH = asa_pkg::MAX_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // Request stream
  input  wire         s_tvalid,
  output logic        s_tready,
  // [19:0] size_bytes, [23:20] align_log2, [43:24] align_bias,
  // [64:44] user_offset, [71:65] zero
  input  wire  [71:0] s_tdata,
  // [0] req_type
  input  wire         s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  // [20:0] block_offset, [41:21] top_offset, [48:42] block_count,
  // [69:49] used_bytes, [90:70] waste_bytes, [97:91] count_peak,
  // [118:98] used_peak, [139:119] waste_peak, [143:140] zero
  output logic [143:0] m_tdata,
  // [2:0] status
  output logic [2:0]  m_tuser,
  // Arena size register
  input  wire         cfg_wen,
  input  wire  [20:0] cfg_wdata
);
  import asa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DEPTH);

  logic [OFS_W-1:0] arena_bytes;
  req_t             s_req;
  res_t             m_res;
  logic             mem_rd_en, mem_wr_en;
  logic [AW-1:0]    mem_rd_addr, mem_wr_addr;
  rec_t             mem_rd_data, mem_wr_data;

  // Hold the arena size
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bytes <= ARENA_RESET;
    end else if (cfg_wen) begin
      arena_bytes <= cfg_wdata;
    end
  end

  // Unpack the request transaction
  always_comb begin
    s_req.req_type    = s_tuser;
    s_req.size_bytes  = s_tdata[19:0];
    s_req.align_log2  = s_tdata[23:20];
    s_req.align_bias  = s_tdata[43:24];
    s_req.user_offset = s_tdata[64:44];
  end

  // Pack the result transaction
  always_comb begin
    m_tdata = {4'b0, m_res.waste_peak, m_res.used_peak, m_res.count_peak,
               m_res.waste_bytes, m_res.used_bytes, m_res.block_count,
               m_res.top_offset, m_res.block_offset};
    m_tuser = m_res.status;
  end

  asa_rec_mem #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_rec_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  asa_ctrl #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .arena_bytes (arena_bytes),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .s_req       (s_req),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .m_res       (m_res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

endmodule

`default_nettype wire

FILE: dv/alloc_checker.sv
// Result checker for the aligned stack allocator: predicts every result of
// the request stream and compares it with the result stream. Depends on asa_pkg.
`default_nettype none

module alloc_checker #(
  parameter int unsigned MAX_DEPTH = asa_pkg::MAX_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  input  wire          s_tready,
  input  wire  [71:0]  s_tdata,
  input  wire          s_tuser,
  input  wire          m_tvalid,
  input  wire          m_tready,
  input  wire  [143:0] m_tdata,
  input  wire  [2:0]   m_tuser,
  input  wire          cfg_wen,
  input  wire  [20:0]  cfg_wdata,
  output int           failures,
  output int           outstanding,
  output int           live_blocks,
  output logic [20:0]  newest_user,
  output logic [20:0]  top_now
);
  import asa_pkg::*;

  // Predicted allocator state
  logic [OFS_W-1:0] arena_reg;
  logic [OFS_W-1:0] top_ptr;
  rec_t             block_recs [MAX_DEPTH];
  int               live;
  logic [OFS_W-1:0] used_sum;
  logic [OFS_W-1:0] waste_sum;
  int               count_hi;
  logic [OFS_W-1:0] used_hi;
  logic [OFS_W-1:0] waste_hi;

  res_t pending_results [$];
  int   results_seen;

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    failures++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) begin
      flag_error($sformatf("result %0d field %s: got %0d, expected %0d",
                           results_seen, name, got, want));
    end
  endtask

  // Apply one request to the predicted state and build its result
  task automatic predict_allocation(input logic kind, input logic [SIZE_W-1:0] size,
                                    input logic [ALIGN_W-1:0] lg,
                                    input logic [SIZE_W-1:0] aoff,
                                    input logic [OFS_W-1:0] uoff, output res_t r);
    logic [63:0]      span;
    logic [63:0]      grain;
    logic [63:0]      base;
    logic [63:0]      fresh_top;
    logic [63:0]      limit;
    logic [OFS_W-1:0] handed;
    status_t          st;
    rec_t             last;
    st     = ST_OK;
    handed = '0;
    limit  = (64'(arena_reg) < (64'd1 << OFFSET_BITS)) ? 64'(arena_reg)
                                                       : (64'd1 << OFFSET_BITS);
    if (kind == KIND_ALLOC) begin
      span      = 64'(aoff) + 64'(HEADER_BYTES);
      grain     = 64'd1 << lg;
      base      = ((64'(top_ptr) + span + grain - 64'd1) & ~(grain - 64'd1)) - span;
      fresh_top = base + 64'(HEADER_BYTES) + 64'(size);
      if (live >= MAX_DEPTH) begin
        st = ST_FULL;
      end else if (fresh_top > limit) begin
        st = ST_NOSPACE;
      end else begin
        block_recs[live].saved_top = top_ptr;
        block_recs[live].user      = OFS_W'(base + 64'(HEADER_BYTES));
        handed    = OFS_W'(base + 64'(HEADER_BYTES));
        waste_sum = waste_sum + OFS_W'(base - 64'(top_ptr));
        top_ptr   = OFS_W'(fresh_top);
        used_sum  = top_ptr;
        live++;
        if (live > count_hi) count_hi = live;
        if (used_sum > used_hi) used_hi = used_sum;
        if (waste_sum > waste_hi) waste_hi = waste_sum;
      end
    end else begin
      if (live == 0) begin
        st = ST_EMPTY;
      end else begin
        last = block_recs[live-1];
        if (uoff != last.user) begin
          st = ST_ORDER;
        end else begin
          // Release the newest block and give its padding back
          waste_sum = waste_sum - OFS_W'(last.user - OFS_W'(HEADER_BYTES) - last.saved_top);
          top_ptr   = last.saved_top;
          used_sum  = top_ptr;
          live--;
        end
      end
    end
    r.status       = st;
    r.block_offset = handed;
    r.top_offset   = top_ptr;
    r.block_count  = CNT_OUT_W'(live);
    r.used_bytes   = used_sum;
    r.waste_bytes  = waste_sum;
    r.count_peak   = CNT_OUT_W'(count_hi);
    r.used_peak    = used_hi;
    r.waste_peak   = waste_hi;
  endtask

  // Track configuration, requests and results on every rising edge
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      arena_reg = ARENA_RESET;
      top_ptr   = '0;
      live      = 0;
      used_sum  = '0;
      waste_sum = '0;
      count_hi  = 0;
      used_hi   = '0;
      waste_hi  = '0;
      failures  = 0;
      results_seen = 0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status       = status_t'(m_tuser);
        got.block_offset = m_tdata[20:0];
        got.top_offset   = m_tdata[41:21];
        got.block_count  = m_tdata[48:42];
        got.used_bytes   = m_tdata[69:49];
        got.waste_bytes  = m_tdata[90:70];
        got.count_peak   = m_tdata[97:91];
        got.used_peak    = m_tdata[118:98];
        got.waste_peak   = m_tdata[139:119];
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no request waiting", results_seen));
        end else begin
          want = pending_results.pop_front();
          check_field("status", got.status, want.status);
          check_field("block_offset", got.block_offset, want.block_offset);
          check_field("top_offset", got.top_offset, want.top_offset);
          check_field("block_count", got.block_count, want.block_count);
          check_field("used_bytes", got.used_bytes, want.used_bytes);
          check_field("waste_bytes", got.waste_bytes, want.waste_bytes);
          check_field("count_peak", got.count_peak, want.count_peak);
          check_field("used_peak", got.used_peak, want.used_peak);
          check_field("waste_peak", got.waste_peak, want.waste_peak);
        end
        results_seen++;
      end
      if (cfg_wen) arena_reg = cfg_wdata;
      if (s_tvalid && s_tready) begin
        predict_allocation(s_tuser, s_tdata[19:0], s_tdata[23:20], s_tdata[43:24],
                           s_tdata[64:44], want);
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
    live_blocks = live;
    newest_user = (live > 0) ? block_recs[live-1].user : '0;
    top_now     = top_ptr;
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Top of the aligned stack allocator testbench: clock, reset, request and
// arena stimulus, result stalls and the verdict. Depends on asa_pkg,
// aligned_stack_allocator and alloc_checker.
`default_nettype none

module testbench;
  import asa_pkg::*;

  localparam int   CYCLE_LIMIT = 500000;
  localparam int   PHASES      = 8;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;   // [19:0] size, [23:20] align_log2, [43:24] align_bias,
                           // [64:44] user_offset, [71:65] zero
  logic         s_tuser;   // [0] req_type
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_wen;
  logic [20:0]  cfg_wdata;

  int          failures;
  int          outstanding;
  int          live_blocks;
  logic [20:0] newest_user;
  logic [20:0] top_now;

  int          cycle_count = 0;
  int          items_sent  = 0;
  int          hold_req    = 0;
  bit          gaps_on     = 1'b1;
  logic [20:0] arena_now   = ARENA_RESET;

  aligned_stack_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  alloc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .failures    (failures),
    .outstanding (outstanding),
    .live_blocks (live_blocks),
    .newest_user (newest_user),
    .top_now     (top_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(99) < 17);
      end
    end
  end

  function automatic longint arena_limit();
    return (longint'(arena_now) < (64'd1 << OFFSET_BITS)) ? longint'(arena_now)
                                                          : (64'd1 << OFFSET_BITS);
  endfunction

  // Offer one request; called and returns at a falling edge
  task automatic send_request(input logic kind, input logic [19:0] size,
                              input logic [3:0] lg, input logic [19:0] aoff,
                              input logic [20:0] uoff);
    while (gaps_on && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, uoff, aoff, lg, size};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_free(input logic [20:0] uoff);
    send_request(KIND_FREE, 20'($urandom), 4'($urandom), 20'($urandom), uoff);
  endtask

  // Random allocation; tiny keeps blocks small enough to fill the record stack
  task automatic send_random_alloc(input bit tiny);
    logic [19:0] size;
    logic [19:0] aoff;
    logic [3:0]  lg;
    int          pick;
    longint      room;
    room = arena_limit() - longint'(top_now) - longint'(HEADER_BYTES);
    pick = $urandom_range(99);
    lg   = tiny ? 4'($urandom_range(4)) : 4'($urandom_range(15));
    if (tiny) size = 20'($urandom_range(31));
    else if (pick < 65) size = 20'($urandom_range(255));
    else if (pick < 85) size = 20'($urandom_range(8191));
    else if (pick < 93 || room < 0 || room >= (1 << 20) - 1) size = 20'($urandom);
    else begin
      // Exact fit or one byte over, with no padding
      size = 20'(room + $urandom_range(1));
      lg   = '0;
    end
    pick = $urandom_range(99);
    if (pick < 60) aoff = 20'($urandom_range(63));
    else if (pick < 92) aoff = 20'($urandom);
    else aoff = 20'hFFFFF;
    send_request(KIND_ALLOC, size, lg, aoff, 21'($urandom));
  endtask

  task automatic send_random_item();
    int pick;
    int guard;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // Fill burst: enough small blocks to run out of records
      repeat (66) send_random_alloc(1'b1);
    end else if (pick < 11) begin
      // Drain burst: free in order down to empty
      guard = 0;
      while (live_blocks > 0 && guard < 70) begin
        send_free(newest_user);
        guard++;
      end
    end else if (pick < 60) begin
      send_random_alloc(1'b0);
    end else if (pick < 90) begin
      send_free(newest_user);
    end else if (pick < 95) begin
      send_free(21'($urandom));
    end else begin
      send_free(newest_user ^ (21'd1 << $urandom_range(20)));
    end
  endtask

  // Let every result come back, then pause past the latency
  task automatic settle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_arena(input logic [20:0] value);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    arena_now  = value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Request stimulus and verdict
  initial begin
    logic [20:0] arena_vals [PHASES];
    int          phase_items [PHASES];
    int          start;
    arena_vals  = '{21'h1FFFFF, 21'd100000, 21'd0, 21'd4096, 21'd1, 21'($urandom),
                    21'd1048576, 21'd1048575};
    phase_items = '{300, 250, 50, 250, 50, 250, 300, 200};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = KIND_ALLOC;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Directed: empty free, zero size, no space, largest alignment and offset,
    // out-of-order frees, exact fit at the arena end, then unwind to empty
    send_free(21'd0);
    send_request(KIND_ALLOC, 20'd0, 4'd0, 20'd0, 21'h1FFFFF);
    send_request(KIND_ALLOC, 20'hFFFFF, 4'd0, 20'd0, 21'd0);
    send_request(KIND_ALLOC, 20'd5, 4'd15, 20'hFFFFF, 21'd0);
    send_request(KIND_ALLOC, 20'd100, 4'd12, 20'd0, 21'd0);
    send_free(newest_user ^ 21'd1);
    send_free(21'h1FFFFF);
    send_free(newest_user);
    send_request(KIND_ALLOC, 20'd7, 4'd13, 20'd3, 21'd0);
    send_request(KIND_ALLOC, 20'(arena_limit() - top_now - HEADER_BYTES), 4'd0,
                 20'd0, 21'd0);
    send_request(KIND_ALLOC, 20'd0, 4'd0, 20'd0, 21'd0);
    while (live_blocks > 0) send_free(newest_user);
    send_free(newest_user);

    // Random phases, each under its own arena size
    for (int p = 0; p < PHASES; p++) begin
      write_arena(arena_vals[p]);
      gaps_on = (p != 1);
      start   = items_sent;
      if (p == 0) begin
        // Hold off the result side while requests keep coming
        hold_req = 300;
        repeat (40) send_random_item();
      end
      while (items_sent - start < phase_items[p]) send_random_item();
    end

    settle();
    repeat (12) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/asa_pkg.sv
design/asa_rec_mem.sv
design/asa_ctrl.sv
design/aligned_stack_allocator.sv
dv/alloc_checker.sv
dv/testbench.sv
